>>> rtl/fup_pkg.sv
// shared types, codes and the hex digit lookup for the form body parser
package fup_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);
  localparam int unsigned QueueIdxW  = $clog2(QueueDepth);

  localparam logic [7:0] ChrPlus    = 8'h2B;
  localparam logic [7:0] ChrPercent = 8'h25;
  localparam logic [7:0] ChrEquals  = 8'h3D;
  localparam logic [7:0] ChrAmp     = 8'h26;
  localparam logic [7:0] ChrSpace   = 8'h20;
  localparam logic [7:0] ChrZero    = 8'h30;
  localparam logic [7:0] ChrNine    = 8'h39;
  localparam logic [7:0] ChrUpperA  = 8'h41;
  localparam logic [7:0] ChrUpperF  = 8'h46;

  typedef enum logic [2:0] {
    EV_NAME_BYTE  = 3'd0,
    EV_VALUE_BYTE = 3'd1,
    EV_NAME_END   = 3'd2,
    EV_VALUE_END  = 3'd3,
    EV_ERROR      = 3'd4
  } ev_t;

  typedef enum logic [1:0] {
    MODE_NAME  = 2'd0,
    MODE_VALUE = 2'd1,
    MODE_ERROR = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_HI   = 2'd1,
    ESC_LO   = 2'd2
  } esc_t;

  typedef struct packed {
    ev_t        ev;
    logic [7:0] data;
    logic       last;
  } res_t;

  // uppercase hex digit value, 16 for anything else
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [7:0] d;
    d = 8'd16;
    if (b >= ChrZero && b <= ChrNine) begin
      d = b - ChrZero;
    end else if (b >= ChrUpperA && b <= ChrUpperF) begin
      d = b - ChrUpperA + 8'd10;
    end
    return d[4:0];
  endfunction

endpackage

>>> rtl/form_urlencoded_parser_core.sv
// form body parser: splits an urlencoded byte stream into name and value events
//
// Input channel s_axis: one body byte per beat in tdata; tlast set marks the end
// of the body (tdata is then ignored) and flushes any pending field.
// Output channel m_axis: one event per beat. tuser carries the event code
// (0 name byte, 1 value byte, 2 name end, 3 value end, 4 error), tdata the
// decoded byte for byte events and zero otherwise, tlast marks the final
// event caused by one input beat. An input beat causes zero, one or two events.
// The first event of a beat is offered in the cycle after it is accepted when no
// older events wait; a second event follows once the first is taken.
// Throughput: one input beat per cycle; the parse is a single combinational
// pass between the parser state registers and a four-entry result queue, and
// s_axis_tready drops only when the queue holds more than two events, so the
// sustained rate is set by the output side at one event per cycle.
// Reset clears the parser state and empties the queue. When the receiver
// stalls, events wait in the queue and input is held off once it is full
// enough that a two-event beat might not fit.
module form_urlencoded_parser_core
  import fup_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,   // end_of_body
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic [2:0] m_axis_tuser,   // [2:0] event_res
  output logic       m_axis_tlast    // last_of_run
);

  mode_t      mode, mode_next;
  esc_t       esc, esc_next;
  logic [4:0] hi_nib, hi_nib_next;
  logic       nonempty, nonempty_next;
  logic       seen, seen_next;

  res_t                 q [QueueDepth];
  res_t                 q_next [QueueDepth];
  logic [QueueCntW-1:0] cnt, cnt_next;

  logic       s_fire, m_fire;
  logic       f_en, g_en;
  res_t       f_res, g_res;
  res_t       r0, r1;
  logic [1:0] n_res;
  logic [7:0] flush_byte;
  logic [7:0] lo_byte;
  logic [4:0] digit;
  ev_t        byte_ev;

  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_fire        = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (cnt <= QueueCntW'(QueueDepth - 2));
  assign m_axis_tvalid = (cnt != '0);
  assign m_axis_tdata  = q[0].data;
  assign m_axis_tuser  = q[0].ev;
  assign m_axis_tlast  = q[0].last;

  assign digit   = hex_digit(s_axis_tdata);
  assign byte_ev = (mode == MODE_VALUE) ? EV_VALUE_BYTE : EV_NAME_BYTE;

  // escape cut short: each missing digit counts as 16
  always_comb begin
    logic [4:0] h;
    logic [4:0] hp1;
    h          = (esc == ESC_HI) ? 5'd16 : hi_nib;
    hp1        = h + 5'd1;
    flush_byte = {hp1[3:0], 4'd0};
    lo_byte    = {hi_nib[3:0], 4'd0} + {3'd0, digit};
  end

  // parse one beat
  always_comb begin
    mode_next     = mode;
    esc_next      = esc;
    hi_nib_next   = hi_nib;
    nonempty_next = nonempty;
    seen_next     = seen;
    f_en          = 1'b0;
    g_en          = 1'b0;
    f_res         = '{ev: byte_ev, data: flush_byte, last: 1'b0};
    g_res         = '{ev: EV_ERROR, data: 8'd0, last: 1'b0};

    if (s_axis_tlast) begin
      if (mode == MODE_NAME || mode == MODE_VALUE) begin
        f_en = (esc != ESC_NONE);
        if (mode == MODE_VALUE) begin
          g_en     = 1'b1;
          g_res.ev = EV_VALUE_END;
        end else if (nonempty) begin
          g_en     = 1'b1;
          g_res.ev = seen ? EV_VALUE_END : EV_ERROR;
        end
      end
      mode_next     = MODE_NAME;
      esc_next      = ESC_NONE;
      hi_nib_next   = '0;
      nonempty_next = 1'b0;
      seen_next     = 1'b0;
    end else if (mode != MODE_NAME && mode != MODE_VALUE) begin
      // error holds until end of body
    end else if (mode == MODE_NAME && (s_axis_tdata == ChrAmp ||
                 (s_axis_tdata == ChrEquals && !nonempty))) begin
      mode_next   = MODE_ERROR;
      esc_next    = ESC_NONE;
      hi_nib_next = '0;
      g_en        = 1'b1;
    end else if (mode == MODE_NAME && s_axis_tdata == ChrEquals) begin
      f_en          = (esc != ESC_NONE);
      g_en          = 1'b1;
      g_res.ev      = EV_NAME_END;
      mode_next     = MODE_VALUE;
      seen_next     = 1'b1;
      nonempty_next = 1'b0;
      esc_next      = ESC_NONE;
      hi_nib_next   = '0;
    end else if (mode == MODE_VALUE && s_axis_tdata == ChrAmp) begin
      f_en          = (esc != ESC_NONE);
      g_en          = 1'b1;
      g_res.ev      = EV_VALUE_END;
      mode_next     = MODE_NAME;
      nonempty_next = 1'b0;
      esc_next      = ESC_NONE;
      hi_nib_next   = '0;
    end else begin
      nonempty_next = 1'b1;
      g_res.ev      = byte_ev;
      case (esc)
        ESC_HI: begin
          hi_nib_next = digit;
          esc_next    = ESC_LO;
        end
        ESC_LO: begin
          g_en        = 1'b1;
          g_res.data  = lo_byte;
          esc_next    = ESC_NONE;
          hi_nib_next = '0;
        end
        default: begin
          if (s_axis_tdata == ChrPercent) begin
            esc_next = ESC_HI;
          end else if (s_axis_tdata == ChrPlus) begin
            g_en       = 1'b1;
            g_res.data = ChrSpace;
          end else begin
            g_en       = 1'b1;
            g_res.data = s_axis_tdata;
          end
        end
      endcase
    end
  end

  // pack the flushed byte and the main event into slots, flag the final one
  always_comb begin
    r0    = f_en ? f_res : g_res;
    r1    = g_res;
    n_res = {1'b0, f_en} + {1'b0, g_en};
    r0.last = (n_res == 2'd1);
    r1.last = 1'b1;
  end

  // result queue: head at entry 0, shifts on every output beat
  always_comb begin
    logic [QueueCntW-1:0] base;
    base = cnt - {{(QueueCntW-1){1'b0}}, m_fire};
    for (int i = 0; i < QueueDepth - 1; i++) begin
      q_next[i] = m_fire ? q[i+1] : q[i];
    end
    q_next[QueueDepth-1] = q[QueueDepth-1];
    cnt_next = base;
    if (s_fire) begin
      if (n_res != 2'd0) begin
        q_next[base[QueueIdxW-1:0]] = r0;
      end
      if (n_res == 2'd2) begin
        q_next[base[QueueIdxW-1:0] + QueueIdxW'(1)] = r1;
      end
      cnt_next = base + {{(QueueCntW-2){1'b0}}, n_res};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_NAME;
      esc      <= ESC_NONE;
      hi_nib   <= '0;
      nonempty <= 1'b0;
      seen     <= 1'b0;
      cnt      <= '0;
    end else begin
      if (s_fire) begin
        mode     <= mode_next;
        esc      <= esc_next;
        hi_nib   <= hi_nib_next;
        nonempty <= nonempty_next;
        seen     <= seen_next;
      end
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QueueDepth; i++) begin
      q[i] <= q_next[i];
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= QueueCntW'(QueueDepth))
    else $error("result queue overfilled");

  a_eob_clears: assert property (@(posedge clk) disable iff (rst)
    s_fire && s_axis_tlast |=> mode == MODE_NAME && esc == ESC_NONE && !seen && !nonempty)
    else $error("end of body did not clear parser state");

  a_error_no_escape: assert property (@(posedge clk) disable iff (rst)
    mode == MODE_ERROR |-> esc == ESC_NONE)
    else $error("escape pending in error mode");

  a_end_zero_byte: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != EV_NAME_BYTE && m_axis_tuser != EV_VALUE_BYTE
    |-> m_axis_tdata == 8'd0)
    else $error("non-byte event carries data");

endmodule
